[rtl/core/monl_pkg.sv]
// monl_pkg: shared types and constants for the morton octree neighbor list
// used by every module under rtl/core, no dependencies
`default_nettype none

package monl_pkg;

    // field widths of the request and result items
    localparam int IDX_W     = 30;
    localparam int LVL_W     = 4;
    localparam int CNT_W     = 5;

    // deepest level that is accepted
    localparam int MAX_LEVEL = 10;

    // bits per coordinate that a 30-bit box number can carry
    localparam int COORD_W   = IDX_W / 3;

    // per-axis offset codes: coordinate minus one, itself, plus one
    localparam int AXIS_W = 2;
    localparam logic [AXIS_W-1:0] OFF_LO  = 2'd0;
    localparam logic [AXIS_W-1:0] OFF_MID = 2'd1;
    localparam logic [AXIS_W-1:0] OFF_HI  = 2'd2;

    // request item
    typedef struct packed {
        logic [IDX_W-1:0] box_index;
        logic [LVL_W-1:0] tree_level;
    } req_t;

    // result item
    typedef struct packed {
        logic [IDX_W-1:0] neighbour_index;
        logic [CNT_W-1:0] neighbour_count;
        logic             last_of_run;
        logic             bad_request;
    } rsp_t;

    // which side neighbors exist along one axis
    typedef struct packed {
        logic has_lo;
        logic has_hi;
    } axis_span_t;

    // classified job handed from the front end to the back end
    typedef struct packed {
        logic               bad;
        logic [COORD_W-1:0] cx;
        logic [COORD_W-1:0] cy;
        logic [COORD_W-1:0] cz;
        axis_span_t         sx;
        axis_span_t         sy;
        axis_span_t         sz;
        logic [CNT_W-1:0]   total;
    } job_t;

    // current offset triple of the back-end walk
    typedef struct packed {
        logic [AXIS_W-1:0] dx;
        logic [AXIS_W-1:0] dy;
        logic [AXIS_W-1:0] dz;
    } offs_t;

    // job queue status
    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

endpackage

`default_nettype wire

[rtl/core/monl_front.sv]
// monl_front: checks a request, splits the box number into x, y, z
// and works out which neighbors exist; depends on monl_pkg
`default_nettype none

module monl_front #(
    parameter int MAX_LEVEL = monl_pkg::MAX_LEVEL
) (
    input  monl_pkg::req_t req,
    output monl_pkg::job_t job
);
    import monl_pkg::*;

    localparam int MW = COORD_W + 1;

    logic [LVL_W-1:0]   lvl;
    logic [5:0]         shamt;
    logic               box_over;
    logic               lvl_bad;
    logic               wide_lvl;
    logic [COORD_W-1:0] lvl_mask;
    logic [COORD_W-1:0] cx;
    logic [COORD_W-1:0] cy;
    logic [COORD_W-1:0] cz;
    axis_span_t         sx;
    axis_span_t         sy;
    axis_span_t         sz;
    logic [CNT_W-1:0]   prod;

    // range checks on level and box number
    always_comb
    begin
        lvl      = req.tree_level;
        shamt    = 6'(lvl) * 6'd3;
        box_over = (req.box_index >> shamt) != '0;
        lvl_bad  = (lvl == '0) || (5'(lvl) > 5'(MAX_LEVEL));
    end

    // de-interleave, x bit highest in each triple
    always_comb
    begin
        for (int j = 0; j < COORD_W; j++)
        begin
            cx[j] = req.box_index[3*j+2];
            cy[j] = req.box_index[3*j+1];
            cz[j] = req.box_index[3*j];
        end
    end

    // face clipping per axis
    always_comb
    begin
        wide_lvl  = 5'(lvl) > 5'(COORD_W);
        lvl_mask  = COORD_W'((MW'(1) << lvl) - MW'(1));
        sx.has_lo = cx != '0;
        sy.has_lo = cy != '0;
        sz.has_lo = cz != '0;
        sx.has_hi = wide_lvl || (cx != lvl_mask);
        sy.has_hi = wide_lvl || (cy != lvl_mask);
        sz.has_hi = wide_lvl || (cz != lvl_mask);
        prod = (5'd1 + 5'(sx.has_lo) + 5'(sx.has_hi))
             * (5'd1 + 5'(sy.has_lo) + 5'(sy.has_hi))
             * (5'd1 + 5'(sz.has_lo) + 5'(sz.has_hi));
    end

    // job word, cleared on a rejected request
    always_comb
    begin
        if (lvl_bad || box_over)
        begin
            job       = '0;
            job.bad   = 1'b1;
        end
        else
        begin
            job.bad   = 1'b0;
            job.cx    = cx;
            job.cy    = cy;
            job.cz    = cz;
            job.sx    = sx;
            job.sy    = sy;
            job.sz    = sz;
            job.total = prod - 5'd1;
        end
    end

endmodule

`default_nettype wire

[rtl/core/monl_queue.sv]
// monl_queue: two-entry job queue between front and back end
// depends on monl_pkg
`default_nettype none

module monl_queue (
    input  wire              clk,
    input  wire              rst_n,
    input  wire              push,
    input  monl_pkg::job_t   wr_data,
    input  wire              pop,
    output monl_pkg::job_t   rd_data,
    output monl_pkg::q_stat_t stat
);
    import monl_pkg::*;

    job_t       slot_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;

    // status and head entry
    always_comb
    begin
        stat.full  = count_reg == 2'd2;
        stat.empty = count_reg == 2'd0;
        rd_data    = slot_reg[rd_ptr_reg];
    end

    // pointer and count update
    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

`default_nettype wire

[rtl/core/monl_back.sv]
// monl_back: walks the neighbor offsets of the head job into an output
// register, one result a cycle unless stalled; depends on monl_pkg
`default_nettype none

module monl_back (
    input  wire             clk,
    input  wire             rst_n,
    input  monl_pkg::job_t  head,
    input  wire             head_valid,
    output logic            pop,
    output logic            out_valid,
    input  wire             out_ready,
    output monl_pkg::rsp_t  out_item
);
    import monl_pkg::*;

    function automatic logic [AXIS_W-1:0] lo_off(axis_span_t s);
        return s.has_lo ? OFF_LO : OFF_MID;
    endfunction

    function automatic logic [AXIS_W-1:0] hi_off(axis_span_t s);
        return s.has_hi ? OFF_HI : OFF_MID;
    endfunction

    // advance z, then y, then x
    function automatic offs_t step(offs_t p, job_t j);
        offs_t r;
        r = p;
        if (p.dz != hi_off(j.sz))
        begin
            r.dz = p.dz + 2'd1;
        end
        else
        begin
            r.dz = lo_off(j.sz);
            if (p.dy != hi_off(j.sy))
            begin
                r.dy = p.dy + 2'd1;
            end
            else
            begin
                r.dy = lo_off(j.sy);
                r.dx = p.dx + 2'd1;
            end
        end
        return r;
    endfunction

    // step over the box itself
    function automatic offs_t skip_self(offs_t p, job_t j);
        logic self;
        self = (p.dx == OFF_MID) && (p.dy == OFF_MID) && (p.dz == OFF_MID);
        return self ? step(p, j) : p;
    endfunction

    offs_t              pos_reg;
    offs_t              pos_next;
    logic               first_reg;
    logic               first_next;
    logic [CNT_W-1:0]   n_reg;
    logic [CNT_W-1:0]   n_next;
    logic               out_valid_reg;
    logic               out_valid_next;
    rsp_t               out_item_reg;
    rsp_t               out_item_next;

    offs_t              start;
    offs_t              cur;
    logic               emit;
    logic               last;
    logic [COORD_W-1:0] nx;
    logic [COORD_W-1:0] ny;
    logic [COORD_W-1:0] nz;
    logic [IDX_W-1:0]   nidx;

    // current offset and neighbor coordinates
    always_comb
    begin
        start = skip_self('{dx: lo_off(head.sx), dy: lo_off(head.sy),
                            dz: lo_off(head.sz)}, head);
        cur   = first_reg ? start : pos_reg;
        nx    = head.cx + COORD_W'(cur.dx) - COORD_W'(1);
        ny    = head.cy + COORD_W'(cur.dy) - COORD_W'(1);
        nz    = head.cz + COORD_W'(cur.dz) - COORD_W'(1);
    end

    // re-interleave
    always_comb
    begin
        for (int j = 0; j < COORD_W; j++)
        begin
            nidx[3*j+2] = nx[j];
            nidx[3*j+1] = ny[j];
            nidx[3*j]   = nz[j];
        end
    end

    // issue control
    always_comb
    begin
        emit = head_valid && (!out_valid_reg || out_ready);
        last = head.bad || ((n_reg + 5'd1) == head.total);
        pop  = emit && last;
    end

    // next walk position and output register
    always_comb
    begin
        pos_next       = pos_reg;
        first_next     = first_reg;
        n_next         = n_reg;
        out_valid_next = out_valid_reg;
        out_item_next  = out_item_reg;
        if (emit)
        begin
            out_valid_next                = 1'b1;
            out_item_next.neighbour_index = head.bad ? '0 : nidx;
            out_item_next.neighbour_count = head.total;
            out_item_next.last_of_run     = last;
            out_item_next.bad_request     = head.bad;
            if (last)
            begin
                first_next = 1'b1;
                n_next     = '0;
            end
            else
            begin
                first_next = 1'b0;
                n_next     = n_reg + 5'd1;
                pos_next   = skip_self(step(cur, head), head);
            end
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            first_reg     <= 1'b1;
            n_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pos_reg       <= pos_next;
            first_reg     <= first_next;
            n_reg         <= n_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_item_reg <= out_item_next;
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

endmodule

`default_nettype wire

[rtl/core/morton_octree_neighbour_list.sv]
// morton_octree_neighbour_list: top level, front end, job queue, back end
// depends on monl_pkg, monl_front, monl_queue, monl_back
`default_nettype none

// Takes a Morton box number (x bit highest in each triple) and its level and
// returns every same-level neighbor, x outermost and z innermost, ascending,
// 7 to 26 results per request, each carrying the total count and a last mark
// on the final one. A level outside 1..MAX_LEVEL or a box number of 8^level
// or more returns a single result with bad_request set and a count of zero.
// The back end issues one result per cycle into an output register unless
// out_ready stalls it, and a request occupies it until its last result
// issues. Requests are classified on intake and wait in a two-entry queue;
// the request being walked keeps its entry until its last result issues, so
// one more request can be taken while it is walked and in_ready then stays
// low until that walk ends. When the back end is free, the first result of
// a request passes through its queue entry and then the output register.
module morton_octree_neighbour_list #(
    parameter int MAX_LEVEL = monl_pkg::MAX_LEVEL
) (
    input  wire              clk,
    input  wire              rst_n,
    input  wire              in_valid,
    output logic             in_ready,
    input  monl_pkg::req_t   in_item,
    output logic             out_valid,
    input  wire              out_ready,
    output monl_pkg::rsp_t   out_item
);
    import monl_pkg::*;

    job_t    new_job;
    job_t    head;
    q_stat_t q_stat;
    logic    push;
    logic    pop;

    // intake
    assign in_ready = !q_stat.full;
    assign push     = in_valid && in_ready;

    monl_front #(
        .MAX_LEVEL (MAX_LEVEL)
    ) u_front (
        .req (in_item),
        .job (new_job)
    );

    monl_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .wr_data (new_job),
        .pop     (pop),
        .rd_data (head),
        .stat    (q_stat)
    );

    monl_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head),
        .head_valid (!q_stat.empty),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_item   (out_item)
    );

`ifndef SYNTHESIS
    // a rejected request is a single result with a zero count
    a_bad_single: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_item.bad_request)
        |-> (out_item.last_of_run && out_item.neighbour_count == '0))
        else $error("bad request result not a lone zero-count result");

    // a good request reports between 7 and 26 neighbors
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_item.bad_request)
        |-> (out_item.neighbour_count >= 5'd7 && out_item.neighbour_count <= 5'd26))
        else $error("neighbor count out of range");

    // a run continues without a gap and keeps its count
    a_run_gapless: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && !out_item.last_of_run)
        |=> (out_valid && out_item.neighbour_count == $past(out_item.neighbour_count)))
        else $error("gap or count change inside a neighbor run");
`endif

endmodule

`default_nettype wire

[sim/tb_morton_octree_neighbour_list.sv]
// tb_morton_octree_neighbour_list: self-checking bench for the octree neighbor lister
// depends on monl_pkg and morton_octree_neighbour_list, predicts every neighbor result itself
`default_nettype none

module tb_morton_octree_neighbour_list;
    timeunit 1ns;
    timeprecision 1ps;

    import monl_pkg::*;

    localparam int   RAND_PER_PHASE = 73;
    localparam int   HOLD_CYCLES    = 400;
    localparam int   DRAIN_CYCLES   = 40;
    localparam rsp_t ERR_RSP = '{neighbour_index: '0, neighbour_count: '0,
                                 last_of_run: 1'b1, bad_request: 1'b1};

    // one directed row, with a typed-in result where it is obvious
    typedef struct packed {
        req_t req;
        logic fixed;
        rsp_t rsp;
    } dir_row_t;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    req_t in_item;
    logic out_valid;
    logic out_ready = 1'b0;
    rsp_t out_item;

    rsp_t pending_neighbours[$];
    int   fail_count;
    int   items_sent;
    int   bad_items;
    int   results_seen;
    int   idle_pct;
    int   stall_pct;
    int   hold_req;
    int   hold_seen;
    int   hold_left;

    morton_octree_neighbour_list dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item)
    );

    // 12 ns clock
    initial clk = 1'b0;
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // interleave three coordinates into a box number, x bit highest in each triple
    function automatic logic [IDX_W-1:0] interleave_xyz(int unsigned x, int unsigned y,
                                                        int unsigned z, int unsigned lvl);
        logic [63:0] m;
        m = '0;
        for (int j = 0; j < lvl; j++)
        begin
            m[3*j+2] = x[j];
            m[3*j+1] = y[j];
            m[3*j]   = z[j];
        end
        return m[IDX_W-1:0];
    endfunction

    // expected neighbor results of one request, queued in emission order
    function automatic void predict_neighbours(req_t r);
        logic [63:0] wide_box;
        int unsigned lvl;
        int unsigned top;
        int unsigned cx;
        int unsigned cy;
        int unsigned cz;
        int unsigned total;
        int unsigned n;
        int          px;
        int          py;
        int          pz;
        rsp_t        e;
        wide_box = 64'(r.box_index);
        lvl      = r.tree_level;
        if (lvl < 1 || lvl > MAX_LEVEL || (wide_box >> (3 * lvl)) != 0)
        begin
            pending_neighbours.push_back(ERR_RSP);
            bad_items++;
            return;
        end
        cx = 0;
        cy = 0;
        cz = 0;
        for (int j = 0; j < lvl; j++)
        begin
            cx |= int'(r.box_index[3*j+2]) << j;
            cy |= int'(r.box_index[3*j+1]) << j;
            cz |= int'(r.box_index[3*j]) << j;
        end
        top   = (1 << lvl) - 1;
        total = (int'(cx > 0) + 1 + int'(cx < top)) * (int'(cy > 0) + 1 + int'(cy < top))
                * (int'(cz > 0) + 1 + int'(cz < top)) - 1;
        n = 0;
        // x outermost, z innermost, each ascending, clipped at the faces
        for (int ix = -1; ix <= 1; ix++)
            for (int iy = -1; iy <= 1; iy++)
                for (int iz = -1; iz <= 1; iz++)
                begin
                    px = int'(cx) + ix;
                    py = int'(cy) + iy;
                    pz = int'(cz) + iz;
                    if (ix == 0 && iy == 0 && iz == 0)
                        continue;
                    if (px < 0 || py < 0 || pz < 0 || px > int'(top) || py > int'(top)
                        || pz > int'(top))
                        continue;
                    e.neighbour_index = interleave_xyz(px, py, pz, lvl);
                    e.neighbour_count = CNT_W'(total);
                    e.last_of_run     = (n + 1 == total);
                    e.bad_request     = 1'b0;
                    pending_neighbours.push_back(e);
                    n++;
                end
    endfunction

    // coordinate biased toward the cube faces
    function automatic int unsigned pick_coord(int unsigned lvl);
        int unsigned top;
        top = (1 << lvl) - 1;
        case ($urandom_range(4))
            0: return 0;
            1: return top;
            2: return (top > 0) ? 1 : 0;
            default: return $urandom() & top;
        endcase
    endfunction

    // mostly well-formed requests, some bad levels and out-of-range boxes
    function automatic req_t random_request();
        req_t        r;
        int unsigned lvl;
        int unsigned kind;
        kind = $urandom_range(99);
        if (kind < 6)
        begin
            r.tree_level = $urandom_range(1) ? LVL_W'(0) : LVL_W'($urandom_range(11, 15));
            r.box_index  = IDX_W'($urandom());
        end
        else if (kind < 12)
        begin
            lvl          = $urandom_range(1, 9);
            r.tree_level = LVL_W'(lvl);
            r.box_index  = IDX_W'($urandom());
            r.box_index[$urandom_range(3 * lvl, IDX_W - 1)] = 1'b1;
        end
        else
        begin
            lvl          = $urandom_range(1) ? MAX_LEVEL : $urandom_range(1, MAX_LEVEL);
            r.tree_level = LVL_W'(lvl);
            r.box_index  = interleave_xyz(pick_coord(lvl), pick_coord(lvl), pick_coord(lvl),
                                          lvl);
        end
        return r;
    endfunction

    // offer one request, hold it until the transfer, then queue what it should produce
    task automatic offer_request(input req_t r, input logic fixed, input rsp_t fixed_rsp);
        while ($urandom_range(99) < idle_pct)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
        @(negedge clk);
        in_valid <= 1'b1;
        in_item  <= r;
        do
            @(posedge clk);
        while (!in_ready);
        items_sent++;
        if (fixed)
        begin
            pending_neighbours.push_back(fixed_rsp);
            bad_items++;
        end
        else
            predict_neighbours(r);
    endtask

    // receiver: random stalls, plus one long hold-off when asked
    always @(negedge clk)
    begin
        if (hold_seen != hold_req)
        begin
            hold_seen = hold_req;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_ready <= 1'b0;
        end
        else
            out_ready <= ($urandom_range(99) >= stall_pct);
    end

    // result check against the oldest expectation
    always @(posedge clk)
    begin
        rsp_t e;
        if (rst_n && out_valid && out_ready)
        begin
            results_seen++;
            if (pending_neighbours.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual %h", $realtime,
                         out_item);
                fail_count++;
            end
            else
            begin
                e = pending_neighbours.pop_front();
                if (out_item.neighbour_index !== e.neighbour_index)
                begin
                    $display("%0t: neighbour_index expected %h actual %h", $realtime,
                             e.neighbour_index, out_item.neighbour_index);
                    fail_count++;
                end
                if (out_item.neighbour_count !== e.neighbour_count)
                begin
                    $display("%0t: neighbour_count expected %0d actual %0d", $realtime,
                             e.neighbour_count, out_item.neighbour_count);
                    fail_count++;
                end
                if (out_item.last_of_run !== e.last_of_run)
                begin
                    $display("%0t: last_of_run expected %b actual %b", $realtime,
                             e.last_of_run, out_item.last_of_run);
                    fail_count++;
                end
                if (out_item.bad_request !== e.bad_request)
                begin
                    $display("%0t: bad_request expected %b actual %b", $realtime,
                             e.bad_request, out_item.bad_request);
                    fail_count++;
                end
            end
        end
    end

    // watchdog
    initial
    begin
        #5_000_000;
        $display("Verification failed");
        $finish;
    end

    // main sequence
    initial
    begin
        dir_row_t dir_rows[] = '{
            // bad level and box out of range: single error result
            '{req: '{box_index: 30'h0,        tree_level: 4'd0},  fixed: 1'b1, rsp: ERR_RSP},
            '{req: '{box_index: 30'h0,        tree_level: 4'd11}, fixed: 1'b1, rsp: ERR_RSP},
            '{req: '{box_index: 30'h3FFFFFFF, tree_level: 4'd15}, fixed: 1'b1, rsp: ERR_RSP},
            '{req: '{box_index: 30'h3FFFFFFF, tree_level: 4'd0},  fixed: 1'b1, rsp: ERR_RSP},
            '{req: '{box_index: 30'h8,        tree_level: 4'd1},  fixed: 1'b1, rsp: ERR_RSP},
            '{req: '{box_index: 30'h40,       tree_level: 4'd2},  fixed: 1'b1, rsp: ERR_RSP},
            '{req: '{box_index: 30'h08000000, tree_level: 4'd9},  fixed: 1'b1, rsp: ERR_RSP},
            '{req: '{box_index: 30'h20000000, tree_level: 4'd9},  fixed: 1'b1, rsp: ERR_RSP},
            // corners at levels 1, 2 and 10
            '{req: '{box_index: 30'h0,        tree_level: 4'd1},  fixed: 1'b0, rsp: '0},
            '{req: '{box_index: 30'h7,        tree_level: 4'd1},  fixed: 1'b0, rsp: '0},
            '{req: '{box_index: 30'h5,        tree_level: 4'd1},  fixed: 1'b0, rsp: '0},
            '{req: '{box_index: 30'h0,        tree_level: 4'd10}, fixed: 1'b0, rsp: '0},
            '{req: '{box_index: 30'h3FFFFFFF, tree_level: 4'd10}, fixed: 1'b0, rsp: '0},
            '{req: '{box_index: 30'h3F,       tree_level: 4'd2},  fixed: 1'b0, rsp: '0},
            // interior boxes, full set of 26
            '{req: '{box_index: 30'h7,        tree_level: 4'd2},  fixed: 1'b0, rsp: '0},
            '{req: '{box_index: 30'h38000000, tree_level: 4'd10}, fixed: 1'b0, rsp: '0},
            '{req: '{box_index: 30'h2AAAAAAA, tree_level: 4'd10}, fixed: 1'b0, rsp: '0},
            '{req: '{box_index: 30'h15555555, tree_level: 4'd10}, fixed: 1'b0, rsp: '0},
            // two more corners and a face
            '{req: '{box_index: 30'h1B6,      tree_level: 4'd3},  fixed: 1'b0, rsp: '0},
            '{req: '{box_index: 30'h092,      tree_level: 4'd3},  fixed: 1'b0, rsp: '0},
            '{req: '{box_index: 30'h1FFFFFF,  tree_level: 4'd9},  fixed: 1'b0, rsp: '0}
        };

        rst_n        = 1'b0;
        in_valid     = 1'b0;
        in_item      = '0;
        fail_count   = 0;
        items_sent   = 0;
        bad_items    = 0;
        results_seen = 0;
        idle_pct     = 0;
        stall_pct    = 0;
        hold_req     = 0;

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed rows
        foreach (dir_rows[i])
            offer_request(dir_rows[i].req, dir_rows[i].fixed, dir_rows[i].rsp);

        // random phases: no idling with a long receiver hold-off, then sender gaps,
        // receiver stalls, and both together
        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 56; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 56; end
                default: begin idle_pct = 26; stall_pct = 26; end
            endcase
            if (ph == 0)
                hold_req++;
            for (int k = 0; k < RAND_PER_PHASE; k++)
                offer_request(random_request(), 1'b0, '0);
        end

        @(negedge clk);
        in_valid <= 1'b0;

        // drain
        while (pending_neighbours.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("run covered %0d requests (%0d rejected), %0d neighbor results checked",
                 items_sent, bad_items, results_seen);
        $display("phases: no idling with a long output hold-off, sender gaps, output stalls, both");
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

`default_nettype wire
